/* hw/rtl/cbpo_pkg.sv */
// Shared constants and types for the circle/box push-out pipeline.
`default_nettype none

package cbpo_pkg;

    // Default coordinate width (signed Q16.8 at 24 bits).
    localparam int CBPO_COORD_WIDTH = 24;

    // Pipeline control handed to the sub-pipelines.
    typedef struct packed {
        logic en;   // whole pipeline advances
        logic vld;  // beat entering the first stage
    } t_pipe_ctl;

endpackage

`default_nettype wire

/* hw/rtl/cbpo_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module cbpo_isqrt
    import cbpo_pkg::*;
#(
    parameter int RB   = 24,
    parameter int SB_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_pipe_ctl         i_ctl,
    input  wire logic [2*RB-1:0]   i_rad,
    input  wire logic [SB_W-1:0]   i_sb,
    output logic                   o_vld,
    output logic [RB-1:0]          o_root,
    output logic [SB_W-1:0]        o_sb
);

    localparam int NB = 2 * RB;
    localparam int RW = RB + 2;

    wire logic            s_vld  [0:RB];
    wire logic [RW-1:0]   s_rem  [0:RB];
    wire logic [RB-1:0]   s_root [0:RB];
    wire logic [NB-1:0]   s_rad  [0:RB];
    wire logic [SB_W-1:0] s_sb   [0:RB];

    assign s_vld[0]  = i_ctl.vld;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_rad[0]  = i_rad;
    assign s_sb[0]   = i_sb;

    for (genvar j = 0; j < RB; j++) begin : g_stage
        logic [RW-1:0]   w_sh;
        logic [RW-1:0]   w_trial;
        logic [RW-1:0]   w_diff;
        logic            w_ge;
        logic            r_vld;
        logic [RW-1:0]   r_rem;
        logic [RB-1:0]   r_root;
        logic [NB-1:0]   r_rad;
        logic [SB_W-1:0] r_sb;

        // remainder stays below 2*root+1, so its low RB bits carry it
        always_comb begin
            w_sh    = {s_rem[j][RW-3:0], s_rad[j][NB-1 -: 2]};
            w_trial = {s_root[j], 2'b01};
            w_ge    = (w_sh >= w_trial);
            w_diff  = w_sh - w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld <= s_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem  <= w_ge ? w_diff : w_sh;
                r_root <= {s_root[j][RB-2:0], w_ge};
                r_rad  <= {s_rad[j][NB-3:0], 2'b00};
                r_sb   <= s_sb[j];
            end
        end

        assign s_vld[j+1]  = r_vld;
        assign s_rem[j+1]  = r_rem;
        assign s_root[j+1] = r_root;
        assign s_rad[j+1]  = r_rad;
        assign s_sb[j+1]   = r_sb;
    end

    assign o_vld  = s_vld[RB];
    assign o_root = s_root[RB];
    assign o_sb   = s_sb[RB];

endmodule

`default_nettype wire

/* hw/rtl/cbpo_div.sv */
// Two-lane pipelined multiply-divide: floor(a*ov/c) and remainder, one ov bit per stage.
`default_nettype none

module cbpo_div
    import cbpo_pkg::*;
#(
    parameter int NS   = 23,
    parameter int DW   = 24,
    parameter int QW   = 24,
    parameter int SB_W = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_pipe_ctl             i_ctl,
    input  wire logic [1:0][NS-1:0]    i_a,
    input  wire logic [DW-1:0]         i_c,
    input  wire logic [NS-1:0]         i_ov,
    input  wire logic [SB_W-1:0]       i_sb,
    output logic                       o_vld,
    output logic [1:0][QW-1:0]         o_q,
    output logic [1:0][DW-1:0]         o_rem,
    output logic [DW-1:0]              o_c,
    output logic [SB_W-1:0]            o_sb
);

    wire logic               s_vld [0:NS];
    wire logic [1:0][DW-1:0] s_rem [0:NS];
    wire logic [1:0][QW-1:0] s_q   [0:NS];
    wire logic [1:0][NS-1:0] s_a   [0:NS];
    wire logic [DW-1:0]      s_c   [0:NS];
    wire logic [NS-1:0]      s_ov  [0:NS];
    wire logic [SB_W-1:0]    s_sb  [0:NS];

    assign s_vld[0] = i_ctl.vld;
    assign s_rem[0] = '0;
    assign s_q[0]   = '0;
    assign s_a[0]   = i_a;
    assign s_c[0]   = i_c;
    assign s_ov[0]  = i_ov;
    assign s_sb[0]  = i_sb;

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [1:0][DW-1:0] w_rem;
        logic [1:0][QW-1:0] w_q;
        logic               r_vld;
        logic [1:0][DW-1:0] r_rem;
        logic [1:0][QW-1:0] r_q;
        logic [1:0][NS-1:0] r_a;
        logic [DW-1:0]      r_c;
        logic [NS-1:0]      r_ov;
        logic [SB_W-1:0]    r_sb;

        // a <= c and rem < c, so 2*rem + a < 3c: at most two subtractions of c
        always_comb begin
            logic [DW+1:0] t;
            logic [DW+1:0] c1;
            logic [DW+1:0] c2;
            logic [DW+1:0] sel;
            logic [1:0]    k;
            c1 = {2'b00, s_c[j]};
            c2 = {1'b0, s_c[j], 1'b0};
            for (int l = 0; l < 2; l++) begin
                t = {1'b0, s_rem[j][l], 1'b0}
                    + (s_ov[j][NS-1] ? {{(DW+2-NS){1'b0}}, s_a[j][l]} : '0);
                if (t >= c2) begin
                    sel = t - c2;
                    k   = 2'd2;
                end else if (t >= c1) begin
                    sel = t - c1;
                    k   = 2'd1;
                end else begin
                    sel = t;
                    k   = 2'd0;
                end
                w_rem[l] = sel[DW-1:0];
                w_q[l]   = {s_q[j][l][QW-2:0], 1'b0} + {{(QW-2){1'b0}}, k};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld <= s_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem <= w_rem;
                r_q   <= w_q;
                r_a   <= s_a[j];
                r_c   <= s_c[j];
                r_ov  <= {s_ov[j][NS-2:0], 1'b0};
                r_sb  <= s_sb[j];
            end
        end

        assign s_vld[j+1] = r_vld;
        assign s_rem[j+1] = r_rem;
        assign s_q[j+1]   = r_q;
        assign s_a[j+1]   = r_a;
        assign s_c[j+1]   = r_c;
        assign s_ov[j+1]  = r_ov;
        assign s_sb[j+1]  = r_sb;
    end

    assign o_vld = s_vld[NS];
    assign o_q   = s_q[NS];
    assign o_rem = s_rem[NS];
    assign o_c   = s_c[NS];
    assign o_sb  = s_sb[NS];

endmodule

`default_nettype wire

/* hw/rtl/circle_box_push_out_top.sv */
// Circle versus axis-aligned box overlap resolution, fully pipelined.
//
//  channel   dir  fields (tdata from bit 0 up)
//  s_axis    in   circle_x, circle_y, radius, box_x, box_y, box_width, box_height
//  m_axis    out  new_x, new_y; tuser = pushed
//
//  One beat accepted per cycle while o_s_axis_tready is high;
//  RB = min(COORD_WIDTH, 32) square-root stages.
//  Square root and the multiply-divide each retire one bit per stage.
//  Synchronous active-low reset clears the valid bits only.
//  A downstream stall freezes the pipe only when the output register and the
//  last stage both hold beats; bubbles keep draining otherwise.
`default_nettype none

module circle_box_push_out_top
    import cbpo_pkg::*;
#(
    parameter int COORD_WIDTH = CBPO_COORD_WIDTH
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // circle_x, circle_y, radius, box_x, box_y, box_width, box_height, zero pad
    input  wire logic [((7*COORD_WIDTH-3+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                         o_m_axis_tvalid,
    input  wire logic                                    i_m_axis_tready,
    // new_x, new_y, zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]           o_m_axis_tdata,
    // pushed
    output logic                                         o_m_axis_tuser
);

    localparam int W      = COORD_WIDTH;
    localparam int UW     = W - 1;
    localparam int SQ     = (W > 32) ? (W - 32) : 0;
    localparam int SW     = UW - SQ;
    localparam int RB     = SW + 1;
    localparam int NB     = 2 * RB;
    localparam int DW     = W;
    localparam int OUT_TW = ((2 * W + 7) / 8) * 8;

    localparam int OFF_CY = W;
    localparam int OFF_R  = 2 * W;
    localparam int OFF_BX = 2 * W + UW;
    localparam int OFF_BY = 3 * W + UW;
    localparam int OFF_BW = 4 * W + UW;
    localparam int OFF_BH = 4 * W + 2 * UW;

    typedef struct packed {
        logic [W-1:0]  cx;
        logic [W-1:0]  cy;
        logic [UW-1:0] r;
        logic [UW-1:0] ax;
        logic [UW-1:0] ay;
        logic          sgx;
        logic          sgy;
        logic          go;
    } t_sq_sb;

    typedef struct packed {
        logic [W-1:0] cx;
        logic [W-1:0] cy;
        logic         sgx;
        logic         sgy;
        logic         push;
    } t_dv_sb;

    // center minus the center clamped into [b - ext/2, b + ext/2]
    function automatic logic [W+1:0] f_offset(input logic [W-1:0] c, input logic [W-1:0] b,
                                              input logic [UW-1:0] ext);
        logic signed [W+1:0] ce;
        logic signed [W+1:0] be;
        logic signed [W+1:0] he;
        logic signed [W+1:0] lo;
        logic signed [W+1:0] hi;
        logic signed [W+1:0] cl;
        ce = $signed({{2{c[W-1]}}, c});
        be = $signed({{2{b[W-1]}}, b});
        he = $signed({4'b0000, ext[UW-1:1]});
        lo = be - he;
        hi = be + he;
        cl = ce;
        if (cl > hi) cl = hi;
        if (cl < lo) cl = lo;
        return ce - cl;
    endfunction

    function automatic logic [W:0] f_mag(input logic [W+1:0] d);
        logic [W+1:0] m;
        m = d[W+1] ? (~d + 1'b1) : d;
        return m[W:0];
    endfunction

    function automatic logic [W-1:0] f_sat_add(input logic [W-1:0] c, input logic [W-1:0] q,
                                               input logic neg);
        logic signed [W:0] s;
        logic signed [W:0] p;
        p = $signed({1'b0, q});
        s = $signed({c[W-1], c}) + (neg ? -p : p);
        if (s[W] != s[W-1]) begin
            return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return s[W-1:0];
    endfunction

    logic w_adv;
    logic r_f2_vld;
    logic r_out_vld;

    assign w_adv           = !r_f2_vld || !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // stage 1: clamp and offsets
    logic            r_s1_vld;
    logic [W+1:0]    r_s1_dx;
    logic [W+1:0]    r_s1_dy;
    logic [W-1:0]    r_s1_cx;
    logic [W-1:0]    r_s1_cy;
    logic [UW-1:0]   r_s1_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_dx <= f_offset(i_s_axis_tdata[W-1:0], i_s_axis_tdata[OFF_BX +: W],
                                i_s_axis_tdata[OFF_BW +: UW]);
            r_s1_dy <= f_offset(i_s_axis_tdata[OFF_CY +: W], i_s_axis_tdata[OFF_BY +: W],
                                i_s_axis_tdata[OFF_BH +: UW]);
            r_s1_cx <= i_s_axis_tdata[W-1:0];
            r_s1_cy <= i_s_axis_tdata[OFF_CY +: W];
            r_s1_r  <= i_s_axis_tdata[OFF_R +: UW];
        end
    end

    // stage 2: magnitudes and the overlap precheck
    logic [W:0]      w_ax;
    logic [W:0]      w_ay;
    logic            r_s2_vld;
    t_sq_sb          r_s2_sb;
    logic [SW-1:0]   r_s2_sx;
    logic [SW-1:0]   r_s2_sy;

    assign w_ax = f_mag(r_s1_dx);
    assign w_ay = f_mag(r_s1_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_sb.cx  <= r_s1_cx;
            r_s2_sb.cy  <= r_s1_cy;
            r_s2_sb.r   <= r_s1_r;
            r_s2_sb.ax  <= w_ax[UW-1:0];
            r_s2_sb.ay  <= w_ay[UW-1:0];
            r_s2_sb.sgx <= r_s1_dx[W+1];
            r_s2_sb.sgy <= r_s1_dy[W+1];
            r_s2_sb.go  <= (w_ax != '0 || w_ay != '0)
                           && (w_ax < {2'b00, r_s1_r}) && (w_ay < {2'b00, r_s1_r});
            r_s2_sx     <= w_ax[UW-1:SQ];
            r_s2_sy     <= w_ay[UW-1:SQ];
        end
    end

    // stage 3: squares
    logic            r_s3_vld;
    t_sq_sb          r_s3_sb;
    logic [2*SW-1:0] r_s3_sqx;
    logic [2*SW-1:0] r_s3_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_adv) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_sb  <= r_s2_sb;
            r_s3_sqx <= r_s2_sx * r_s2_sx;
            r_s3_sqy <= r_s2_sy * r_s2_sy;
        end
    end

    // stage 4: sum of squares
    logic            r_s4_vld;
    t_sq_sb          r_s4_sb;
    logic [NB-1:0]   r_s4_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_adv) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_sb  <= r_s3_sb;
            r_s4_rad <= {2'b00, r_s3_sqx} + {2'b00, r_s3_sqy};
        end
    end

    t_pipe_ctl       w_sq_ctl;
    logic            w_sq_vld;
    logic [RB-1:0]   w_root;
    t_sq_sb          w_sq_sb;

    assign w_sq_ctl = '{en: w_adv, vld: r_s4_vld};

    cbpo_isqrt #(
        .RB   (RB),
        .SB_W ($bits(t_sq_sb))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sq_ctl),
        .i_rad   (r_s4_rad),
        .i_sb    (r_s4_sb),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_sb    (w_sq_sb)
    );

    // m1: distance is at least the larger offset
    logic [DW-1:0]   w_d0;
    logic [DW-1:0]   w_d1;
    logic [DW-1:0]   w_axe;
    logic [DW-1:0]   w_aye;
    logic            r_m1_vld;
    t_sq_sb          r_m1_sb;
    logic [DW-1:0]   r_m1_dist;

    assign w_d0  = DW'(w_root) << SQ;
    assign w_axe = DW'(w_sq_sb.ax);
    assign w_aye = DW'(w_sq_sb.ay);
    assign w_d1  = (w_d0 < w_axe) ? w_axe : w_d0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (w_adv) begin
            r_m1_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_sb   <= w_sq_sb;
            r_m1_dist <= (w_d1 < w_aye) ? w_aye : w_d1;
        end
    end

    // m2: overlap; a non-push beat divides 0 by 1
    logic            w_push;
    logic [DW-1:0]   w_re;
    logic [DW-1:0]   w_ov_full;
    logic            r_m2_vld;
    t_dv_sb          r_m2_sb;
    logic [1:0][UW-1:0] r_m2_a;
    logic [UW-1:0]   r_m2_ov;
    logic [DW-1:0]   r_m2_c;

    assign w_re      = DW'(r_m1_sb.r);
    assign w_push    = r_m1_sb.go && (w_re > r_m1_dist);
    assign w_ov_full = w_re - r_m1_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (w_adv) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m2_sb.cx   <= r_m1_sb.cx;
            r_m2_sb.cy   <= r_m1_sb.cy;
            r_m2_sb.sgx  <= r_m1_sb.sgx;
            r_m2_sb.sgy  <= r_m1_sb.sgy;
            r_m2_sb.push <= w_push;
            r_m2_a       <= {r_m1_sb.ay, r_m1_sb.ax};
            r_m2_ov      <= w_push ? w_ov_full[UW-1:0] : '0;
            r_m2_c       <= w_push ? r_m1_dist : DW'(1);
        end
    end

    t_pipe_ctl          w_dv_ctl;
    logic               w_dv_vld;
    logic [1:0][W-1:0]  w_q;
    logic [1:0][DW-1:0] w_rem;
    logic [DW-1:0]      w_c;
    t_dv_sb             w_dv_sb;

    assign w_dv_ctl = '{en: w_adv, vld: r_m2_vld};

    cbpo_div #(
        .NS   (UW),
        .DW   (DW),
        .QW   (W),
        .SB_W ($bits(t_dv_sb))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dv_ctl),
        .i_a     (r_m2_a),
        .i_c     (r_m2_c),
        .i_ov    (r_m2_ov),
        .i_sb    (r_m2_sb),
        .o_vld   (w_dv_vld),
        .o_q     (w_q),
        .o_rem   (w_rem),
        .o_c     (w_c),
        .o_sb    (w_dv_sb)
    );

    // f1: round half up on the remainder
    logic               r_f1_vld;
    t_dv_sb             r_f1_sb;
    logic [1:0][W-1:0]  r_f1_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (w_adv) begin
            r_f1_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_sb <= w_dv_sb;
            for (int l = 0; l < 2; l++) begin
                r_f1_q[l] <= w_q[l] + W'(w_rem[l] >= (w_c - w_rem[l]));
            end
        end
    end

    // f2: apply sign and saturate
    logic [W-1:0]    r_f2_x;
    logic [W-1:0]    r_f2_y;
    logic            r_f2_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_vld <= 1'b0;
        end else if (w_adv) begin
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f2_x    <= r_f1_sb.push ? f_sat_add(r_f1_sb.cx, r_f1_q[0], r_f1_sb.sgx)
                                      : r_f1_sb.cx;
            r_f2_y    <= r_f1_sb.push ? f_sat_add(r_f1_sb.cy, r_f1_q[1], r_f1_sb.sgy)
                                      : r_f1_sb.cy;
            r_f2_push <= r_f1_sb.push;
        end
    end

    // output register
    logic [W-1:0]    r_out_x;
    logic [W-1:0]    r_out_y;
    logic            r_out_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || i_m_axis_tready) begin
            r_out_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_axis_tready) begin
            r_out_x    <= r_f2_x;
            r_out_y    <= r_f2_y;
            r_out_push <= r_f2_push;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_TW'({r_out_y, r_out_x});
    assign o_m_axis_tuser  = r_out_push;

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_s1_vld)
        else $error("accepted beat did not enter stage 1");

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f2_vld && !w_adv) |=> (r_f2_vld && $stable(r_f2_x) && $stable(r_f2_y)))
        else $error("stalled last stage lost its beat");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m2_vld |-> (r_m2_c != '0))
        else $error("divider fed a zero distance");

    a_no_push_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f1_vld && !r_f1_sb.push) |-> (r_f1_q[0] == '0 && r_f1_q[1] == '0))
        else $error("nonzero push on a beat without overlap");

endmodule

`default_nettype wire

/* verif/circle_box_push_out_top_test.sv */
// Self-checking testbench for the circle/box push-out pipeline.
`timescale 1ns / 1ps
`default_nettype none

module circle_box_push_out_top_test;
    import cbpo_pkg::*;

    localparam int CW = CBPO_COORD_WIDTH;
    localparam int IN_W = ((7*CW-3+7)/8)*8;
    localparam int OUT_W = ((2*CW+7)/8)*8;
    localparam int LATENCY = 9 + CW + (CW - 1);
    localparam longint CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic signed [CW-1:0] cx, cy;
        logic [CW-2:0]        r;
        logic signed [CW-1:0] bx, by;
        logic [CW-2:0]        bw, bh;
    } t_pair;

    typedef struct {
        logic signed [CW-1:0] nx, ny;
        logic                 pushed;
    } t_resolved;

    // directed row: checked against typed value only when has_fixed is set
    typedef struct {
        t_pair     pair;
        bit        has_fixed;
        t_resolved fixed;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic [IN_W-1:0] i_s_axis_tdata = '0;
    logic i_m_axis_tready = 1'b0;
    logic o_s_axis_tready, o_m_axis_tvalid, o_m_axis_tuser;
    logic [OUT_W-1:0] o_m_axis_tdata;

    t_resolved pending_centers[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  pushes_seen = 0;
    int  sent = 0;
    longint cycles = 0;
    int  src_idle_pct = 0, snk_idle_pct = 0;
    bit  hold_sink = 1'b0;
    bit  hold_active = 1'b0;

    circle_box_push_out_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint saturate(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (CW-1)) - 1;
        lo = -(longint'(1) <<< (CW-1));
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic t_resolved resolve_push(t_pair p);
        t_resolved o;
        longint cx, cy, bx, by, hw, hh, dx, dy, qx, qy, px, py;
        logic [127:0] t;
        logic [63:0] ax, ay, rr, reach, ov;
        cx = p.cx; cy = p.cy; bx = p.bx; by = p.by;
        rr = p.r;
        hw = longint'(p.bw >> 1);
        hh = longint'(p.bh >> 1);
        qx = cx > bx + hw ? bx + hw : cx;
        qx = qx < bx - hw ? bx - hw : qx;
        qy = cy > by + hh ? by + hh : cy;
        qy = qy < by - hh ? by - hh : qy;
        dx = cx - qx;
        dy = cy - qy;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        o.nx = CW'(cx);
        o.ny = CW'(cy);
        o.pushed = 1'b0;
        if ((ax != 0 || ay != 0) && ax < rr && ay < rr) begin
            reach = root_floor(ax*ax + ay*ay);
            if (reach < ax) reach = ax;
            if (reach < ay) reach = ay;
            if (rr > reach) begin
                ov = rr - reach;
                // round half up: floor((2*a*ov + reach) / (2*reach))
                t = (128'(ax) * ov * 2 + reach) / (128'(reach) * 2);
                px = longint'(t);
                t = (128'(ay) * ov * 2 + reach) / (128'(reach) * 2);
                py = longint'(t);
                o.nx = CW'(saturate(cx + (dx < 0 ? -px : px)));
                o.ny = CW'(saturate(cy + (dy < 0 ? -py : py)));
                o.pushed = 1'b1;
            end
        end
        return o;
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int span;
        span = $urandom_range(0, 9);
        if (span < 2) begin
            // full range noise
            p.cx = $urandom; p.cy = $urandom; p.r = $urandom;
            p.bx = $urandom; p.by = $urandom; p.bw = $urandom; p.bh = $urandom;
        end else begin
            // circle near a box edge so overlap is likely
            p.bx = $urandom;
            p.by = $urandom;
            if (span == 9) begin
                p.bx = $urandom_range(1, 0) ? {1'b0, {(CW-1){1'b1}}} - 20 : {1'b1, {(CW-1){1'b0}}};
            end
            p.bw = $urandom_range(0, 1 << 16);
            p.bh = $urandom_range(0, 1 << 16);
            p.r  = $urandom_range(0, 1 << (span + 8));
            p.cx = p.bx + $signed(CW'($urandom_range(0, 2 << (span + 8)))) - (1 << (span + 8))
                   + ($urandom_range(0, 1) ? $signed({1'b0, p.bw >> 1}) : -$signed({1'b0, p.bw >> 1}));
            p.cy = p.by + $signed(CW'($urandom_range(0, 2 << (span + 8)))) - (1 << (span + 8))
                   + ($urandom_range(0, 1) ? $signed({1'b0, p.bh >> 1}) : -$signed({1'b0, p.bh >> 1}));
        end
        return p;
    endfunction

    task automatic send_pair(t_pair p);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tdata <= IN_W'({p.bh, p.bw, p.by, p.bx, p.r, p.cy, p.cx});
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_centers.push_back(resolve_push(p));
        sent++;
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_centers.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_row make_row(longint cx, longint cy, longint r, longint bx,
                                      longint by, longint bw, longint bh,
                                      bit fixed_on, longint nx, longint ny, bit pu);
        t_row w;
        w.pair.cx = CW'(cx); w.pair.cy = CW'(cy); w.pair.r = (CW-1)'(r);
        w.pair.bx = CW'(bx); w.pair.by = CW'(by);
        w.pair.bw = (CW-1)'(bw); w.pair.bh = (CW-1)'(bh);
        w.has_fixed = fixed_on;
        w.fixed.nx = CW'(nx); w.fixed.ny = CW'(ny); w.fixed.pushed = pu;
        return w;
    endfunction

    // result side: sample on the edge, drive ready with NBA
    always @(posedge i_clk) begin
        t_resolved want;
        logic signed [CW-1:0] gx, gy;
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                gx = o_m_axis_tdata[CW-1:0];
                gy = o_m_axis_tdata[2*CW-1:CW];
                results_seen <= results_seen + 1;
                if (o_m_axis_tuser) pushes_seen <= pushes_seen + 1;
                if (pending_centers.size() == 0) begin
                    if (mismatches < MAX_SHOWN)
                        $display("unexpected beat: x=%0d y=%0d pushed=%0b", gx, gy,
                                 o_m_axis_tuser);
                    mismatches <= mismatches + 1;
                end else begin
                    want = pending_centers.pop_front();
                    if (gx !== want.nx || gy !== want.ny || o_m_axis_tuser !== want.pushed) begin
                        if (mismatches < MAX_SHOWN)
                            $display("mismatch: exp x=%0d y=%0d p=%0b got x=%0d y=%0d p=%0b",
                                     want.nx, want.ny, want.pushed, gx, gy, o_m_axis_tuser);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            i_m_axis_tready <= !hold_sink && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        int hold_left;
        if (hold_active && !hold_sink) begin
            hold_sink <= 1'b1;
            hold_left = 300;
        end else if (hold_sink) begin
            hold_left--;
            if (hold_left == 0) begin
                hold_sink <= 1'b0;
                hold_active <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("circle_box_push_out_top regression: fail");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        longint maxp, minn;
        maxp = (longint'(1) <<< (CW-1)) - 1;
        minn = -(longint'(1) <<< (CW-1));
        // center inside the box: no push
        rows.push_back(make_row(0, 0, 100, 0, 0, 512, 512, 1, 0, 0, 0));
        // center on the box edge: zero offset
        rows.push_back(make_row(256, 0, 100, 0, 0, 512, 512, 1, 256, 0, 0));
        // no overlap: radius equals distance
        rows.push_back(make_row(300, 0, 44, 0, 0, 512, 512, 1, 300, 0, 0));
        // axis push: dx 44, r 100 -> push 56
        rows.push_back(make_row(300, 0, 100, 0, 0, 512, 512, 1, 356, 0, 1));
        rows.push_back(make_row(-300, 0, 100, 0, 0, 512, 512, 1, -356, 0, 1));
        rows.push_back(make_row(0, -300, 100, 0, 0, 512, 512, 1, 0, -356, 1));
        // overlap of one: push of one, pushed set
        rows.push_back(make_row(300, 0, 45, 0, 0, 512, 512, 1, 301, 0, 1));
        // diagonal corner, rounded push
        rows.push_back(make_row(259, 259, 10, 0, 0, 512, 512, 0, 0, 0, 0));
        rows.push_back(make_row(257, 258, 3, 0, 0, 512, 512, 0, 0, 0, 0));
        rows.push_back(make_row(1000, -777, 5000, 0, 0, 3, 1, 0, 0, 0, 0));
        // saturation at both ends
        rows.push_back(make_row(maxp, 0, maxp, maxp - 100, 0, 20, 20, 1, maxp, 0, 1));
        rows.push_back(make_row(minn, minn, maxp, minn + 10, minn + 10, 2, 2, 1,
                                minn, minn, 1));
        // field extremes
        rows.push_back(make_row(maxp, maxp, maxp, minn, minn, maxp, maxp, 0, 0, 0, 0));
        rows.push_back(make_row(minn, minn, 0, maxp, maxp, 0, 0, 1, minn, minn, 0));
        rows.push_back(make_row(minn, maxp, maxp, maxp, minn, maxp, maxp, 0, 0, 0, 0));
        rows.push_back(make_row(-1, -1, maxp, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        rows.push_back(make_row(1, 0, 1, 0, 0, 1, 1, 1, 1, 0, 0));
        rows.push_back(make_row(1, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_pair(rows[i].pair);
            if (rows[i].has_fixed) pending_centers[$] = rows[i].fixed;
        end
        // sender pauses until everything is back
        drain_results();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = ph == 0 ? 35 : (ph == 1 ? 72 : 0);
            snk_idle_pct = ph == 0 ? 72 : (ph == 1 ? 35 : 0);
            for (int k = 0; k < 460; k++) begin
                if (ph == 2 && k == 50) hold_active = 1'b1;
                if (k % 150 == 149) begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end else if (k % 150 == 0) begin
                    src_idle_pct = ph == 0 ? 35 : (ph == 1 ? 72 : 0);
                    snk_idle_pct = ph == 0 ? 72 : (ph == 1 ? 35 : 0);
                end
                send_pair(random_pair());
            end
        end
        drain_results();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("sent %0d pairs, checked %0d results, %0d with a push, %0d mismatches",
                 sent, results_seen, pushes_seen, mismatches);
        if (mismatches == 0 && pending_centers.size() == 0)
            $display("circle_box_push_out_top regression: pass");
        else
            $display("circle_box_push_out_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/cbpo_pkg.sv
hw/rtl/cbpo_isqrt.sv
hw/rtl/cbpo_div.sv
hw/rtl/circle_box_push_out_top.sv
verif/circle_box_push_out_top_test.sv
